### rtl/mse_pkg.sv
// Shared constants, command codes and state encoding for the MIPS subset execute block.
package mse_pkg;

    localparam int MEM_WORDS = 1024;
    localparam int NUM_REGS  = 32;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int RF_AW     = $clog2(NUM_REGS);
    localparam int CLR_LEN   = (MEM_WORDS > NUM_REGS) ? MEM_WORDS : NUM_REGS;
    localparam int CLR_AW    = $clog2(CLR_LEN);

    localparam logic [31:0] EXIT_CODE      = 32'd10;
    localparam logic [31:0] PRINT_INT_CODE = 32'd1;
    localparam logic [31:0] PRINT_STR_CODE = 32'd4;
    localparam logic [RF_AW-1:0] REG_V0    = RF_AW'(2);
    localparam logic [RF_AW-1:0] REG_A0    = RF_AW'(4);

    localparam logic [1:0] TAG_STRING_HEAD = 2'd1;
    localparam logic [1:0] TAG_INVALID     = 2'd3;

    localparam logic [1:0] PRINT_NONE = 2'd0;
    localparam logic [1:0] PRINT_INT  = 2'd1;
    localparam logic [1:0] PRINT_STR  = 2'd2;

    typedef enum logic [3:0] {
        CMD_ADD     = 4'd0,
        CMD_SUB     = 4'd1,
        CMD_SUBI    = 4'd2,
        CMD_ADDI    = 4'd3,
        CMD_SLT     = 4'd4,
        CMD_LI      = 4'd5,
        CMD_LA      = 4'd6,
        CMD_LW      = 4'd7,
        CMD_SW      = 4'd8,
        CMD_BEQ     = 4'd9,
        CMD_BNE     = 4'd10,
        CMD_J       = 4'd11,
        CMD_SYSCALL = 4'd12,
        CMD_INIT    = 4'd13
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_REG   = 4'b0100,
        ST_MEM   = 4'b1000
    } state_t;

endpackage

### rtl/mips_subset_execute.sv
// Top level: MIPS subset execute block with register file and tagged data memory.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------------------
//  in      | in_valid / in_ready       | cmd dest_reg src_a src_b imm target_line
//          |                           | current_line data_tag
//  out     | out_valid / out_ready     | next_line halt print_kind print_value error
//  cfg     | cfg_we                    | cfg_wdata (data_words_used)
//
// After reset a clearing pass zeroes the register file and the data memory, tags and words;
// in_ready stays low meanwhile, cfg writes are taken as ever.
// An item passes through the transfer with the register file read and an execute step, and
// an in-range lw or a print-string syscall also through a data memory read step.
// The result is registered into the output register at the end of execute, or of the
// memory read for those two; it waits there while the block takes the next item, which
// stalls in execute, or in the memory read, until the output register frees.
module mips_subset_execute (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  cmd,
    input  logic [4:0]  dest_reg,
    input  logic [4:0]  src_a,
    input  logic [4:0]  src_b,
    input  logic signed [31:0] imm,
    input  logic [15:0] target_line,
    input  logic [15:0] current_line,
    input  logic [1:0]  data_tag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] next_line,
    output logic        halt,
    output logic [1:0]  print_kind,
    output logic signed [31:0] print_value,
    output logic        error
);
    import mse_pkg::*;

    logic [31:0] rf [NUM_REGS];
    logic [33:0] dmem [MEM_WORDS];

    state_t state_reg, state_next;
    logic [CLR_AW-1:0] clr_cnt_reg;
    logic [10:0] used_reg;

    cmd_t        cmd_reg;
    logic [4:0]  dest_idx_reg;
    logic [31:0] imm_reg;
    logic [15:0] target_reg;
    logic [15:0] cur_line_reg;
    logic [1:0]  tag_reg;
    logic [31:0] rf_a_reg, rf_b_reg;
    logic [33:0] mem_rd_reg;

    logic        out_valid_reg;
    logic [15:0] next_line_reg;
    logic        halt_reg;
    logic [1:0]  print_kind_reg;
    logic [31:0] print_value_reg;
    logic        error_reg;

    logic        accept, can_finish, fin, go_mem;
    logic [RF_AW-1:0] rf_raddr_a, rf_raddr_b;
    logic [31:0] opb, alu_sum, alu_dif;
    logic        addr_ok, init_ok, str_ok;
    logic [15:0] res_next;
    logic        res_halt, res_err;
    logic [1:0]  res_kind;
    logic [31:0] res_pval;
    logic        rf_we;
    logic [31:0] rf_wdata;
    logic        dm_we_word, dm_we_tag;
    logic [MEM_AW-1:0] dm_waddr, dm_raddr;
    logic        clr_last, clr_mem, clr_rf;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == ST_IDLE);
    assign can_finish = !out_valid_reg || out_ready;

    assign clr_last = (clr_cnt_reg == CLR_AW'(CLR_LEN - 1));
    assign clr_mem  = ({1'b0, clr_cnt_reg} < (CLR_AW + 1)'(MEM_WORDS));
    assign clr_rf   = ({1'b0, clr_cnt_reg} < (CLR_AW + 1)'(NUM_REGS));

    always_comb
    begin
        rf_raddr_a = src_a;
        rf_raddr_b = src_b;
        if (cmd_t'(cmd) == CMD_BEQ || cmd_t'(cmd) == CMD_BNE)
        begin
            rf_raddr_a = dest_reg;
        end
        else if (cmd_t'(cmd) == CMD_SYSCALL)
        begin
            rf_raddr_a = REG_V0;
            rf_raddr_b = REG_A0;
        end
        else if (cmd_t'(cmd) == CMD_SW)
        begin
            rf_raddr_b = dest_reg;
        end
    end

    assign opb     = (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB) ? rf_b_reg : imm_reg;
    assign alu_sum = rf_a_reg + opb;
    assign alu_dif = rf_a_reg - opb;
    assign addr_ok = (alu_sum[1:0] == 2'b00) && !alu_sum[31]
                     && (alu_sum[30:2] < 29'(MEM_WORDS));
    assign init_ok = ({1'b0, target_reg} < 17'(MEM_WORDS)) && (tag_reg != TAG_INVALID);
    assign str_ok  = (rf_b_reg < {21'd0, used_reg}) && (rf_b_reg < 32'(MEM_WORDS))
                     && (mem_rd_reg[33:32] == TAG_STRING_HEAD);

    always_comb
    begin
        res_next   = cur_line_reg + 16'd1;
        res_halt   = 1'b0;
        res_kind   = PRINT_NONE;
        res_pval   = '0;
        res_err    = 1'b0;
        rf_we      = 1'b0;
        rf_wdata   = alu_sum;
        dm_we_word = 1'b0;
        dm_we_tag  = 1'b0;
        dm_waddr   = alu_sum[MEM_AW+1:2];
        dm_raddr   = alu_sum[MEM_AW+1:2];
        go_mem     = 1'b0;
        if (state_reg == ST_REG)
        begin
            unique case (cmd_reg)
                CMD_ADD, CMD_ADDI:
                begin
                    rf_we = 1'b1;
                end
                CMD_SUB, CMD_SUBI:
                begin
                    rf_we    = 1'b1;
                    rf_wdata = alu_dif;
                end
                CMD_SLT:
                begin
                    rf_we    = 1'b1;
                    rf_wdata = {31'd0, $signed(rf_a_reg) < $signed(rf_b_reg)};
                end
                CMD_LI, CMD_LA:
                begin
                    rf_we    = 1'b1;
                    rf_wdata = imm_reg;
                end
                CMD_LW:
                begin
                    go_mem  = addr_ok;
                    res_err = !addr_ok;
                end
                CMD_SW:
                begin
                    dm_we_word = addr_ok;
                    res_err    = !addr_ok;
                end
                CMD_BEQ:
                begin
                    if (rf_a_reg == rf_b_reg)
                    begin
                        res_next = target_reg;
                    end
                end
                CMD_BNE:
                begin
                    if (rf_a_reg != rf_b_reg)
                    begin
                        res_next = target_reg;
                    end
                end
                CMD_J:
                begin
                    res_next = target_reg;
                end
                CMD_SYSCALL:
                begin
                    dm_raddr = rf_b_reg[MEM_AW-1:0];
                    priority if (rf_a_reg == EXIT_CODE)
                    begin
                        res_halt = 1'b1;
                    end
                    else if (rf_a_reg == PRINT_INT_CODE)
                    begin
                        res_kind = PRINT_INT;
                        res_pval = rf_b_reg;
                    end
                    else if (rf_a_reg == PRINT_STR_CODE)
                    begin
                        go_mem = 1'b1;
                    end
                    else
                    begin
                        res_err = 1'b1;
                    end
                end
                CMD_INIT:
                begin
                    dm_waddr   = target_reg[MEM_AW-1:0];
                    dm_we_word = init_ok;
                    dm_we_tag  = init_ok;
                    res_err    = !init_ok;
                end
                default:
                begin
                    res_err = 1'b1;
                end
            endcase
        end
        else if (state_reg == ST_MEM)
        begin
            if (cmd_reg == CMD_LW)
            begin
                rf_we    = 1'b1;
                rf_wdata = mem_rd_reg[31:0];
            end
            else if (str_ok)
            begin
                res_kind = PRINT_STR;
                res_pval = rf_b_reg;
            end
            else
            begin
                res_err = 1'b1;
            end
        end
    end

    assign fin = ((state_reg == ST_REG && !go_mem) || state_reg == ST_MEM) && can_finish;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_REG;
                end
            end
            ST_REG:
            begin
                if (go_mem)
                begin
                    state_next = ST_MEM;
                end
                else if (fin)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MEM:
            begin
                if (fin)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_AW'(1);
            end
            if (cfg_we)
            begin
                used_reg <= cfg_wdata;
            end
            if (fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= cmd_t'(cmd);
            dest_idx_reg <= dest_reg;
            imm_reg      <= imm;
            target_reg   <= target_line;
            cur_line_reg <= current_line;
            tag_reg      <= data_tag;
        end
        if (fin)
        begin
            next_line_reg   <= res_next;
            halt_reg        <= res_halt;
            print_kind_reg  <= res_kind;
            print_value_reg <= res_pval;
            error_reg       <= res_err;
        end
    end

    // register file: cleared during the clearing pass, read at transfer, write at finish
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            if (clr_rf)
            begin
                rf[clr_cnt_reg[RF_AW-1:0]] <= '0;
            end
        end
        else if (fin && rf_we)
        begin
            rf[dest_idx_reg] <= rf_wdata;
        end
        if (accept)
        begin
            rf_a_reg <= rf[rf_raddr_a];
            rf_b_reg <= rf[rf_raddr_b];
        end
    end

    // data memory: tag in the upper bits, word below
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            if (clr_mem)
            begin
                dmem[clr_cnt_reg[MEM_AW-1:0]] <= '0;
            end
        end
        else if (fin)
        begin
            if (dm_we_word)
            begin
                dmem[dm_waddr][31:0] <= (cmd_reg == CMD_INIT) ? imm_reg : rf_b_reg;
            end
            if (dm_we_tag)
            begin
                dmem[dm_waddr][33:32] <= tag_reg;
            end
        end
        if (go_mem)
        begin
            mem_rd_reg <= dmem[dm_raddr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_line   = next_line_reg;
    assign halt        = halt_reg;
    assign print_kind  = print_kind_reg;
    assign print_value = print_value_reg;
    assign error       = error_reg;

    a_accept_to_reg: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_REG)
        else $error("transfer did not enter execute");

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !in_ready)
        else $error("input ready during clearing pass");

    a_mem_after_reg: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MEM |-> ($past(state_reg) == ST_REG || $past(state_reg) == ST_MEM))
        else $error("memory stage entered out of order");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (print_kind == PRINT_NONE || (!halt && !error)) && !(halt && error))
        else $error("conflicting result flags");

endmodule
